// File: rtl/plcf_pkg.sv
// shared types and constants for the pitch layer crossfade block
`default_nettype none
package plcf_pkg;

  localparam int unsigned POINT_W      = 20;
  localparam int unsigned GAIN_W       = 16;
  localparam int unsigned RATIO_W      = 16;
  localparam int unsigned COUNT_W      = 3;
  localparam int unsigned PRESENT_W    = 2;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned NUM_POINTS   = 4;
  localparam int unsigned MAX_LAYERS_D = 4;

  localparam logic [GAIN_W-1:0] UNITY_GAIN = 16'h8000;
  localparam logic [31:0]       GAIN_RND   = 32'h0000_4000;

  // serial divider sizes: dividend covers the fade case (num * 2^15 + s)
  localparam int unsigned DIV_DVD_W = 38;
  localparam int unsigned DIV_DVS_W = 21;
  localparam int unsigned DIV_Q_W   = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_COUNT   = 3'd0,
    CFG_POINT_ZERO    = 3'd1,
    CFG_POINT_ONE     = 3'd2,
    CFG_POINT_TWO     = 3'd3,
    CFG_POINT_THREE   = 3'd4,
    CFG_START_POINT   = 3'd5,
    CFG_STOP_POINT    = 3'd6,
    CFG_VOICE_PRESENT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    VC_START = 2'd0,
    VC_LAYER = 2'd1,
    VC_STOP  = 2'd2
  } voice_class_e;

  typedef struct packed {
    logic               done;
    logic [DIV_Q_W-1:0] quot;
    logic               ovf;
  } div_res_t;

endpackage
`default_nettype wire

// File: rtl/pitch_layer_crossfade_top.sv
// top level of the pitch layer crossfade block
// usage:
//  - input channel (in_valid_i / in_stall_o) takes one request: a pitch
//    update (kind 0, Q16.4) or a master gain update (kind 1, Q1.15)
//  - output channel (out_valid_o / out_stall_i) gives one result per
//    present voice in the order start voice, layers 0 upward, stop voice;
//    out_last_o marks the final result of a request, none if no voice
//  - configuration is a plain write port; it must be written only while idle (user's duty, not enforced)
//  - one request is worked at a time; in_stall_o is high from accept
//    until the last result is taken
//  - per voice on a pitch update: up to two serial divisions (fade, then
//    ratio) of 38 steps each in the shared bit-serial divider, plus
//    sequencing and the gain multiply; absent slots are skipped;
//    a gain update runs only the gain multiply per voice, no division
//  - the serial divider sets the pace: one quotient bit per cycle
//  - reset: config registers zero, master gain unity, all fades zero
//  - a stalled result holds in the output register until taken
`default_nettype none
module pitch_layer_crossfade_top #(
  parameter int unsigned MAX_LAYERS = plcf_pkg::MAX_LAYERS_D
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [plcf_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [plcf_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              in_kind_i,
  input  wire logic [plcf_pkg::POINT_W-1:0]      in_value_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [1:0]                             out_voice_class_o,
  output logic [1:0]                             out_layer_index_o,
  output logic [plcf_pkg::GAIN_W-1:0]            out_voice_gain_o,
  output logic [plcf_pkg::RATIO_W-1:0]           out_pitch_ratio_o,
  output logic                                   out_ratio_valid_o,
  output logic                                   out_last_o
);

  localparam int unsigned PW    = plcf_pkg::POINT_W;
  localparam int unsigned GW    = plcf_pkg::GAIN_W;
  localparam int unsigned SLOTS = MAX_LAYERS + 2;
  localparam int unsigned SW    = $clog2(SLOTS);
  localparam int unsigned DW    = plcf_pkg::DIV_DVD_W;
  localparam int unsigned VW    = plcf_pkg::DIV_DVS_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_NEXT, ST_FDIV, ST_RCHK, ST_RDIV, ST_MUL, ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [plcf_pkg::COUNT_W-1:0]   count_q;
  logic [PW-1:0]                  points_q [plcf_pkg::NUM_POINTS];
  logic [PW-1:0]                  start_pt_q, stop_pt_q;
  logic [plcf_pkg::PRESENT_W-1:0] present_q;

  // voice state
  logic [GW-1:0] master_q;
  logic [GW-1:0] fade_q [SLOTS];

  // per request / per voice work registers
  logic                          kind_q;
  logic [PW-1:0]                 value_q;
  logic [SW-1:0]                 slot_q;
  logic [GW-1:0]                 fade_cur_q;
  logic                          valid_cur_q;
  logic                          lerp_q;
  logic [plcf_pkg::RATIO_W-1:0]  ratio_cur_q;

  // output register
  logic                          out_valid_q, out_last_q, out_rv_q;
  plcf_pkg::voice_class_e        out_class_q;
  logic [1:0]                    out_idx_q;
  logic [GW-1:0]                 out_gain_q;
  logic [plcf_pkg::RATIO_W-1:0]  out_ratio_q;

  // layer count clamped to what is built
  logic [2:0] n;
  assign n = (count_q > 3'(MAX_LAYERS)) ? 3'(MAX_LAYERS) : count_q;

  // which slots hold a present voice, and whether one follows this slot
  logic [SLOTS-1:0] pres;
  logic             more;
  always_comb begin
    more = 1'b0;
    for (int j = 0; j < SLOTS; j++) begin
      if (j == 0) pres[j] = present_q[0];
      else if (j == SLOTS - 1) pres[j] = present_q[1];
      else pres[j] = 3'(j - 1) < n;
      if (SW'(j) > slot_q && pres[j]) more = 1'b1;
    end
  end

  // first layer above the pitch
  logic [2:0] up;
  always_comb begin
    up = n;
    for (int i = plcf_pkg::NUM_POINTS - 1; i >= 0; i--) begin
      if (3'(i) < n && points_q[i] > value_q) up = 3'(i);
    end
  end

  // voice selected by the slot pointer
  logic [1:0]    li;
  logic          is_start, is_stop, is_layer;
  logic [PW-1:0] p_sel, pl, pu;
  assign li       = 2'(slot_q - SW'(1));
  assign is_start = slot_q == '0;
  assign is_stop  = slot_q == SW'(SLOTS - 1);
  assign is_layer = !is_start && !is_stop;
  assign p_sel    = is_start ? start_pt_q : (is_stop ? stop_pt_q : points_q[li]);
  assign pu       = points_q[up[1:0]];
  assign pl       = points_q[2'(up - 3'd1)];

  // edge fade terms
  logic [21:0] t3, s3, e_num;
  logic [22:0] t5;
  logic [23:0] t15;
  assign t3    = 22'(value_q) + 22'({value_q, 1'b0});
  assign t5    = 23'(value_q) + 23'({value_q, 2'b0});
  assign t15   = 24'({value_q, 4'b0}) - 24'(value_q);
  assign s3    = 22'(p_sel) + 22'({p_sel, 1'b0});
  assign e_num = 22'(t15 - 24'(s3));

  // crossfade terms
  logic [PW-1:0] l_den, l_num;

  // plan for the current voice
  logic          plan_div, plan_valid, plan_lerp;
  logic [GW-1:0] plan_fade;
  logic [DW-1:0] plan_dvd;
  logic [VW-1:0] plan_dvs;
  logic          is_edge;

  always_comb begin
    plan_div   = 1'b0;
    plan_valid = 1'b0;
    plan_lerp  = 1'b0;
    plan_fade  = '0;
    plan_dvd   = {1'b0, e_num, 15'b0} + DW'(p_sel);
    plan_dvs   = {p_sel, 1'b0};
    l_den      = pu - pl;
    l_num      = ({1'b0, li} == up - 3'd1) ? (pu - value_q) : (value_q - pl);
    is_edge    = !is_layer || (up == 3'd0 && li == 2'd0);
    if (is_edge) begin
      if (p_sel == '0) begin
        plan_fade = plcf_pkg::UNITY_GAIN;
      end else if (t3 > 22'(p_sel)) begin
        plan_fade  = plcf_pkg::UNITY_GAIN;
        plan_valid = 1'b1;
      end else if (t5 < 23'(p_sel)) begin
        plan_fade = '0;
      end else begin
        plan_div = 1'b1;
      end
    end else begin
      plan_fade = (p_sel != '0) ? '0 : plcf_pkg::UNITY_GAIN;
      if (up == n) begin
        if ({1'b0, li} == n - 3'd1) begin
          plan_fade  = plcf_pkg::UNITY_GAIN;
          plan_valid = p_sel != '0;
        end
      end else if (up != 3'd0) begin
        if ({1'b0, li} == up - 3'd1 || {1'b0, li} == up) begin
          if ({1'b0, li} == up - 3'd1 && pl == '0) begin
            plan_fade = plcf_pkg::UNITY_GAIN;
          end else begin
            plan_div  = 1'b1;
            plan_lerp = 1'b1;
            plan_dvd  = {3'b0, l_num, 15'b0} + DW'(l_den[PW-1:1]);
            plan_dvs  = {1'b0, l_den};
          end
        end
      end
    end
  end

  // shared serial divider
  logic               div_start;
  logic [DW-1:0]      div_dvd;
  logic [VW-1:0]      div_dvs;
  plcf_pkg::div_res_t div_res;

  always_comb begin
    div_start = 1'b0;
    div_dvd   = plan_dvd;
    div_dvs   = plan_dvs;
    if (state_q == ST_NEXT && pres[slot_q] && !kind_q && plan_div) begin
      div_start = 1'b1;
    end else if (state_q == ST_RCHK && valid_cur_q) begin
      div_start = 1'b1;
      div_dvd   = DW'({value_q, 8'b0}) + DW'(p_sel[PW-1:1]);
      div_dvs   = {1'b0, p_sel};
    end
  end

  plcf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .res_o      (div_res)
  );

  // gain multiply
  logic [GW-1:0] fade_sel;
  logic [31:0]   prod;
  assign fade_sel = kind_q ? fade_q[slot_q] : fade_cur_q;
  assign prod     = 32'(master_q) * 32'(fade_sel) + plcf_pkg::GAIN_RND;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      start_pt_q <= '0;
      stop_pt_q  <= '0;
      present_q  <= '0;
      for (int i = 0; i < plcf_pkg::NUM_POINTS; i++) points_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (plcf_pkg::cfg_idx_e'(cfg_index_i))
        plcf_pkg::CFG_LAYER_COUNT:   count_q     <= cfg_data_i[2:0];
        plcf_pkg::CFG_POINT_ZERO:    points_q[0] <= cfg_data_i;
        plcf_pkg::CFG_POINT_ONE:     points_q[1] <= cfg_data_i;
        plcf_pkg::CFG_POINT_TWO:     points_q[2] <= cfg_data_i;
        plcf_pkg::CFG_POINT_THREE:   points_q[3] <= cfg_data_i;
        plcf_pkg::CFG_START_POINT:   start_pt_q  <= cfg_data_i;
        plcf_pkg::CFG_STOP_POINT:    stop_pt_q   <= cfg_data_i;
        plcf_pkg::CFG_VOICE_PRESENT: present_q   <= cfg_data_i[1:0];
        default:                     count_q     <= count_q;
      endcase
    end
  end

  // sequencer: walks the voice slots, one voice at a time
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      master_q    <= plcf_pkg::UNITY_GAIN;
      for (int i = 0; i < SLOTS; i++) fade_q[i] <= '0;
      kind_q      <= 1'b0;
      value_q     <= '0;
      slot_q      <= '0;
      fade_cur_q  <= '0;
      valid_cur_q <= 1'b0;
      lerp_q      <= 1'b0;
      ratio_cur_q <= '0;
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
      out_rv_q    <= 1'b0;
      out_class_q <= plcf_pkg::VC_START;
      out_idx_q   <= '0;
      out_gain_q  <= '0;
      out_ratio_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            kind_q  <= in_kind_i;
            value_q <= in_value_i;
            slot_q  <= '0;
            if (in_kind_i) begin
              master_q <= (in_value_i > PW'(plcf_pkg::UNITY_GAIN))
                          ? plcf_pkg::UNITY_GAIN : GW'(in_value_i);
            end
            state_q <= ST_NEXT;
          end
        end
        ST_NEXT: begin
          if (!pres[slot_q]) begin
            if (is_stop) state_q <= ST_IDLE;
            else slot_q <= slot_q + SW'(1);
          end else if (kind_q) begin
            valid_cur_q <= 1'b0;
            ratio_cur_q <= '0;
            state_q     <= ST_MUL;
          end else begin
            fade_cur_q  <= plan_fade;
            valid_cur_q <= plan_valid;
            lerp_q      <= plan_lerp;
            ratio_cur_q <= '0;
            state_q     <= plan_div ? ST_FDIV : ST_RCHK;
          end
        end
        ST_FDIV: begin
          if (div_res.done) begin
            fade_cur_q  <= div_res.quot[GW-1:0];
            valid_cur_q <= lerp_q || div_res.quot[GW-1:0] != '0;
            state_q     <= ST_RCHK;
          end
        end
        ST_RCHK: begin
          state_q <= valid_cur_q ? ST_RDIV : ST_MUL;
        end
        ST_RDIV: begin
          if (div_res.done) begin
            // saturate the Q8.8 ratio
            ratio_cur_q <= (div_res.ovf || div_res.quot[plcf_pkg::DIV_Q_W-1])
                           ? '1 : div_res.quot[plcf_pkg::RATIO_W-1:0];
            state_q     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (!kind_q) fade_q[slot_q] <= fade_cur_q;
          out_valid_q <= 1'b1;
          out_last_q  <= !more;
          out_rv_q    <= valid_cur_q;
          out_ratio_q <= ratio_cur_q;
          out_gain_q  <= prod[30:15];
          out_class_q <= is_start ? plcf_pkg::VC_START
                         : (is_stop ? plcf_pkg::VC_STOP : plcf_pkg::VC_LAYER);
          out_idx_q   <= is_layer ? li : 2'd0;
          state_q     <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              slot_q  <= slot_q + SW'(1);
              state_q <= ST_NEXT;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign in_stall_o        = state_q != ST_IDLE;
  assign out_valid_o       = out_valid_q;
  assign out_voice_class_o = out_class_q;
  assign out_layer_index_o = out_idx_q;
  assign out_voice_gain_o  = out_gain_q;
  assign out_pitch_ratio_o = out_ratio_q;
  assign out_ratio_valid_o = out_rv_q;
  assign out_last_o        = out_last_q;

endmodule
`default_nettype wire

// File: rtl/plcf_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none
module plcf_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [plcf_pkg::DIV_DVD_W-1:0]   dividend_i,
  input  wire logic [plcf_pkg::DIV_DVS_W-1:0]   divisor_i,
  output plcf_pkg::div_res_t                    res_o
);

  localparam int unsigned DW = plcf_pkg::DIV_DVD_W;
  localparam int unsigned SW = plcf_pkg::DIV_DVS_W;
  localparam int unsigned QW = plcf_pkg::DIV_Q_W;
  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q, done_q, ovf_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] dvd_q;
  logic [SW-1:0] dvs_q, rem_q;
  logic [QW-1:0] quo_q;
  logic [SW:0]   rem_sh;
  logic          ge;

  assign rem_sh = {rem_q, dvd_q[DW-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        ovf_q  <= 1'b0;
        cnt_q  <= CW'(DW);
        dvd_q  <= dividend_i;
        dvs_q  <= divisor_i;
        rem_q  <= '0;
        quo_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge ? SW'(rem_sh - {1'b0, dvs_q}) : SW'(rem_sh);
        dvd_q <= {dvd_q[DW-2:0], 1'b0};
        quo_q <= {quo_q[QW-2:0], ge};
        ovf_q <= ovf_q | quo_q[QW-1];
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.quot = quo_q;
  assign res_o.ovf  = ovf_q;

endmodule
`default_nettype wire

// File: rtl/plcf_chk.sv
// port level checks for the pitch layer crossfade block
`default_nettype none
module plcf_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_stall_o,
  input wire logic        out_valid_o,
  input wire logic        out_stall_i,
  input wire logic [1:0]  out_voice_class_o,
  input wire logic [1:0]  out_layer_index_o,
  input wire logic [15:0] out_voice_gain_o,
  input wire logic [15:0] out_pitch_ratio_o,
  input wire logic        out_ratio_valid_o,
  input wire logic        out_last_o
);

  // a taken request blocks the input on the next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not blocked after a request");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_voice_gain_o)
      && $stable(out_pitch_ratio_o) && $stable(out_last_o))
    else $error("stalled result changed");

  // no request taken while results are still pending
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input ready while a result is pending");

  // ratio is zero unless it is applied
  a_ratio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ratio_valid_o |-> out_pitch_ratio_o == 16'd0)
    else $error("ratio set without ratio_valid");

  // gain never above unity, layer index only on layers
  a_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_voice_gain_o <= 16'h8000
      && (out_voice_class_o == plcf_pkg::VC_LAYER || out_layer_index_o == 2'd0))
    else $error("gain or layer index out of range");

endmodule

bind pitch_layer_crossfade_top plcf_chk u_plcf_chk (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .out_voice_class_o (out_voice_class_o),
  .out_layer_index_o (out_layer_index_o),
  .out_voice_gain_o  (out_voice_gain_o),
  .out_pitch_ratio_o (out_pitch_ratio_o),
  .out_ratio_valid_o (out_ratio_valid_o),
  .out_last_o        (out_last_o)
);
`default_nettype wire

// File: verif/pitch_layer_crossfade_top_tb.sv
// self-checking testbench for the pitch layer crossfade block
`default_nettype none
module pitch_layer_crossfade_top_tb;

  // request kinds on the input channel
  typedef enum bit {
    KIND_PITCH = 1'b0,
    KIND_GAIN  = 1'b1
  } req_kind_e;

  // one voice result as the block should give it
  typedef struct {
    plcf_pkg::voice_class_e cls;
    int unsigned            idx;
    int unsigned            gain;
    int unsigned            ratio;
    bit                     rvalid;
    bit                     last;
  } voice_res_t;

  // directed stimulus row; the typed values apply to the first result only
  typedef struct {
    req_kind_e   kind;
    int unsigned value;
    bit          typed;
    int unsigned gain;
    int unsigned ratio;
    bit          rvalid;
  } dir_row_t;

  localparam int unsigned UNITY    = 32768;
  localparam int unsigned MAX_LAY  = 4;
  localparam int unsigned VAL_MAX  = 1048575;
  localparam int unsigned DRAIN    = 600;    // idle wait after the owed results have drained
  localparam int unsigned WDOG_MAX = 20000;
  localparam int unsigned HOLD_LEN = 400;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [plcf_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [plcf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            in_valid_i;
  logic                            in_stall_o;
  logic                            in_kind_i;
  logic [plcf_pkg::POINT_W-1:0]    in_value_i;
  logic                            out_valid_o;
  logic                            out_stall_i;
  logic [1:0]                      out_voice_class_o;
  logic [1:0]                      out_layer_index_o;
  logic [plcf_pkg::GAIN_W-1:0]     out_voice_gain_o;
  logic [plcf_pkg::RATIO_W-1:0]    out_pitch_ratio_o;
  logic                            out_ratio_valid_o;
  logic                            out_last_o;

  pitch_layer_crossfade_top dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_kind_i         (in_kind_i),
    .in_value_i        (in_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_voice_class_o (out_voice_class_o),
    .out_layer_index_o (out_layer_index_o),
    .out_voice_gain_o  (out_voice_gain_o),
    .out_pitch_ratio_o (out_pitch_ratio_o),
    .out_ratio_valid_o (out_ratio_valid_o),
    .out_last_o        (out_last_o)
  );

  // shadow of the configuration registers
  int unsigned sh_count;
  int unsigned sh_point [MAX_LAY];
  int unsigned sh_start_pt;
  int unsigned sh_stop_pt;
  int unsigned sh_present;

  // shadow of the gain state
  int unsigned sh_master;
  int unsigned sh_lay_fade [MAX_LAY];
  int unsigned sh_start_fade;
  int unsigned sh_stop_fade;

  voice_res_t  voice_q [$];    // results still owed by the block
  int unsigned fail_cnt = 0;
  int unsigned req_cnt;
  int unsigned res_cnt = 0;
  int unsigned phase_cnt;
  int unsigned idle_cyc = 0;
  bit          quiet;          // no idling on either side
  bit          hold_req;       // ask the receiver for one long hold-off
  bit          run_done;

  // clock: period 12
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // fade of start/stop voice and of layer 0 below the first point
  function automatic int unsigned edge_gain(int unsigned s, int unsigned t);
    longint unsigned num, den, sl, tl;
    sl = s;
    tl = t;
    if (s == 0) return UNITY;
    if (3 * tl > sl) return UNITY;
    if (5 * tl < sl) return 0;
    num = 15 * tl - 3 * sl;
    den = 2 * sl;
    return int'((num * UNITY + den / 2) / den);
  endfunction

  function automatic int unsigned lerp_gain(int unsigned num, int unsigned den);
    longint unsigned n, d;
    n = num;
    d = den;
    return int'((n * UNITY + d / 2) / d);
  endfunction

  // Q8.8 ratio with rounding, saturated
  function automatic int unsigned ratio_of(int unsigned v, int unsigned p);
    longint unsigned q;
    if (p == 0) return 0;
    q = ((longint'(v) << 8) + p / 2) / p;
    return (q > 65535) ? 65535 : int'(q);
  endfunction

  function automatic void push_voice(plcf_pkg::voice_class_e cls, int unsigned idx,
                                     int unsigned fade, int unsigned ratio,
                                     bit rv);
    voice_res_t r;
    longint unsigned g;
    g = (longint'(sh_master) * fade + 16384) >> 15;
    r.cls    = cls;
    r.idx    = idx;
    r.gain   = int'(g & 16'hFFFF);
    r.ratio  = rv ? (ratio & 16'hFFFF) : 0;
    r.rvalid = rv;
    r.last   = 1'b0;
    voice_q  = {voice_q, r};
  endfunction

  // crossfade predictor: updates the shadow state and queues the results
  function automatic void crossfade_predict(req_kind_e kind, int unsigned v);
    int unsigned n, up, lo, pl, pu, den;
    int unsigned lay_ratio [MAX_LAY];
    bit          lay_rv [MAX_LAY];
    int unsigned st_ratio, sp_ratio, base;
    bit          st_rv, sp_rv;
    n = (sh_count > MAX_LAY) ? MAX_LAY : sh_count;
    st_ratio = 0; sp_ratio = 0; st_rv = 0; sp_rv = 0;
    for (int i = 0; i < MAX_LAY; i++) begin
      lay_ratio[i] = 0;
      lay_rv[i]    = 0;
    end
    if (kind == KIND_GAIN) begin
      sh_master = (v > UNITY) ? UNITY : v;
    end else begin
      if (sh_present[0]) begin
        sh_start_fade = edge_gain(sh_start_pt, v);
        if (sh_start_fade != 0 && sh_start_pt != 0) begin
          st_rv    = 1;
          st_ratio = ratio_of(v, sh_start_pt);
        end
      end
      if (n > 0) begin
        up = n;
        for (int i = n - 1; i >= 0; i--) if (sh_point[i] > v) up = i;
        for (int i = 0; i < n; i++) sh_lay_fade[i] = (sh_point[i] != 0) ? 0 : UNITY;
        if (up == 0) begin
          sh_lay_fade[0] = edge_gain(sh_point[0], v);
          if (sh_lay_fade[0] != 0 && sh_point[0] != 0) begin
            lay_rv[0]    = 1;
            lay_ratio[0] = ratio_of(v, sh_point[0]);
          end
        end else if (up == n) begin
          sh_lay_fade[n-1] = UNITY;
          if (sh_point[n-1] != 0) begin
            lay_rv[n-1]    = 1;
            lay_ratio[n-1] = ratio_of(v, sh_point[n-1]);
          end
        end else begin
          lo  = up - 1;
          pl  = sh_point[lo];
          pu  = sh_point[up];
          den = pu - pl;
          if (pl != 0) begin
            sh_lay_fade[lo] = lerp_gain(pu - v, den);
            lay_rv[lo]      = 1;
            lay_ratio[lo]   = ratio_of(v, pl);
          end else begin
            sh_lay_fade[lo] = UNITY;
          end
          sh_lay_fade[up] = lerp_gain(v - pl, den);
          lay_rv[up]      = 1;
          lay_ratio[up]   = ratio_of(v, pu);
        end
      end
      if (sh_present[1]) begin
        sh_stop_fade = edge_gain(sh_stop_pt, v);
        if (sh_stop_fade != 0 && sh_stop_pt != 0) begin
          sp_rv    = 1;
          sp_ratio = ratio_of(v, sh_stop_pt);
        end
      end
    end
    base = voice_q.size();
    if (sh_present[0]) push_voice(plcf_pkg::VC_START, 0, sh_start_fade, st_ratio, st_rv);
    for (int i = 0; i < n; i++)
      push_voice(plcf_pkg::VC_LAYER, i, sh_lay_fade[i], lay_ratio[i], lay_rv[i]);
    if (sh_present[1]) push_voice(plcf_pkg::VC_STOP, 0, sh_stop_fade, sp_ratio, sp_rv);
    if (voice_q.size() > base) voice_q[voice_q.size()-1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    fail_cnt++;
  endtask

  // register write, one cycle of write enable; shadow follows
  task automatic cfg_write(plcf_pkg::cfg_idx_e idx, int unsigned data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data[plcf_pkg::CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      plcf_pkg::CFG_LAYER_COUNT:   sh_count    = data & 7;
      plcf_pkg::CFG_POINT_ZERO:    sh_point[0] = data & VAL_MAX;
      plcf_pkg::CFG_POINT_ONE:     sh_point[1] = data & VAL_MAX;
      plcf_pkg::CFG_POINT_TWO:     sh_point[2] = data & VAL_MAX;
      plcf_pkg::CFG_POINT_THREE:   sh_point[3] = data & VAL_MAX;
      plcf_pkg::CFG_START_POINT:   sh_start_pt = data & VAL_MAX;
      plcf_pkg::CFG_STOP_POINT:    sh_stop_pt  = data & VAL_MAX;
      plcf_pkg::CFG_VOICE_PRESENT: sh_present  = data & 3;
      default: ;
    endcase
  endtask

  task automatic cfg_all(int unsigned cnt, int unsigned p0, int unsigned p1,
                         int unsigned p2, int unsigned p3, int unsigned sp,
                         int unsigned tp, int unsigned pres);
    cfg_write(plcf_pkg::CFG_LAYER_COUNT, cnt);
    cfg_write(plcf_pkg::CFG_POINT_ZERO, p0);
    cfg_write(plcf_pkg::CFG_POINT_ONE, p1);
    cfg_write(plcf_pkg::CFG_POINT_TWO, p2);
    cfg_write(plcf_pkg::CFG_POINT_THREE, p3);
    cfg_write(plcf_pkg::CFG_START_POINT, sp);
    cfg_write(plcf_pkg::CFG_STOP_POINT, tp);
    cfg_write(plcf_pkg::CFG_VOICE_PRESENT, pres);
    phase_cnt++;
  endtask

  // drain before touching config; a request with no voice may still be busy
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (voice_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // offer one request, hold it until taken, then predict
  task automatic send_req(req_kind_e kind, int unsigned v, output int unsigned base);
    int unsigned gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_kind_i  <= kind;
    in_value_i <= v[plcf_pkg::POINT_W-1:0];
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    base = voice_q.size();
    crossfade_predict(kind, v);
    req_cnt++;
  endtask

  // random request shaped toward the interesting pitch regions
  task automatic send_random();
    int unsigned v, p, sel, base;
    req_kind_e   kind;
    sel = $urandom_range(0, 9);
    if (sel < 2) begin
      kind = KIND_GAIN;
      case ($urandom_range(0, 3))
        0: v = UNITY;
        1: v = $urandom_range(0, VAL_MAX);
        default: v = $urandom_range(0, UNITY);
      endcase
    end else begin
      kind = KIND_PITCH;
      if (sel < 6) begin
        // around a layer point, including exact hits
        p = sh_point[$urandom_range(0, MAX_LAY - 1)];
        case ($urandom_range(0, 3))
          0: v = p;
          1: v = (p > 0) ? p - 1 : 0;
          default: v = $urandom_range((p > p / 2) ? p - p / 2 : 0,
                                      (p + p / 2 > VAL_MAX) ? VAL_MAX : p + p / 2);
        endcase
      end else if (sel < 8) begin
        // around a start or stop fade ramp
        p = $urandom_range(0, 1) ? sh_start_pt : sh_stop_pt;
        v = $urandom_range(p / 6, p / 2 + 1);
      end else begin
        v = $urandom_range(0, 1) ? $urandom_range(0, VAL_MAX) : $urandom_range(0, 4095);
      end
    end
    send_req(kind, v, base);
  endtask

  // mostly ascending points with random spacing, sometimes an unpitched layer 0
  task automatic cfg_random(int unsigned span);
    int unsigned pts [MAX_LAY];
    int unsigned acc;
    acc = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, span);
    for (int i = 0; i < MAX_LAY; i++) begin
      pts[i] = acc;
      acc    = acc + $urandom_range(1, span);
      if (acc > VAL_MAX) acc = VAL_MAX;
    end
    if ($urandom_range(0, 4) == 0) begin
      // points out of order
      for (int i = 0; i < MAX_LAY; i++) pts[i] = $urandom_range(0, span * 4);
    end
    cfg_all($urandom_range(0, 7), pts[0], pts[1], pts[2], pts[3],
            $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, span * 5),
            $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, span * 5),
            $urandom_range(0, 3));
  endtask

  // directed rows under count 4, points 1600/3200/4800/6400, start 8000,
  // stop 16000, both edge voices present; typed values are the start voice
  dir_row_t dir_tab [16] = '{
    '{KIND_GAIN,  VAL_MAX, 1'b1, 0,     0,     1'b0},  // master saturates, fade still 0
    '{KIND_PITCH, 0,       1'b1, 0,     0,     1'b0},  // far below the start ramp
    '{KIND_PITCH, VAL_MAX, 1'b1, UNITY, 33554, 1'b1},  // top of range, all above
    '{KIND_PITCH, 2400,    1'b0, 0,     0,     1'b0},
    '{KIND_GAIN,  0,       1'b1, 0,     0,     1'b0},  // master muted
    '{KIND_GAIN,  32769,   1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 1599,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 1600,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 2666,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 2667,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 3200,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 4000,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 6400,    1'b0, 0,     0,     1'b0},
    '{KIND_PITCH, 7000,    1'b0, 0,     0,     1'b0},
    '{KIND_GAIN,  16384,   1'b0, 0,     0,     1'b0},
    '{KIND_GAIN,  UNITY,   1'b0, 0,     0,     1'b0}
  };

  // stimulus and phase control
  initial begin
    int unsigned base;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= plcf_pkg::CFG_LAYER_COUNT;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    in_kind_i   <= KIND_PITCH;
    in_value_i  <= '0;
    sh_count = 0; sh_start_pt = 0; sh_stop_pt = 0; sh_present = 0;
    sh_master = UNITY; sh_start_fade = 0; sh_stop_fade = 0;
    for (int i = 0; i < MAX_LAY; i++) begin
      sh_point[i]    = 0;
      sh_lay_fade[i] = 0;
    end
    req_cnt = 0; phase_cnt = 0;
    quiet = 1'b0; hold_req = 1'b0; run_done = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // out of reset nothing is present: requests change state, give no result
    send_req(KIND_PITCH, 5000, base);
    send_req(KIND_GAIN, 20000, base);
    send_req(KIND_GAIN, UNITY, base);
    wait_idle();

    // directed table
    cfg_all(4, 1600, 3200, 4800, 6400, 8000, 16000, 3);
    foreach (dir_tab[i]) begin
      send_req(dir_tab[i].kind, dir_tab[i].value, base);
      if (dir_tab[i].typed) begin
        voice_q[base].gain   = dir_tab[i].gain;
        voice_q[base].ratio  = dir_tab[i].ratio;
        voice_q[base].rvalid = dir_tab[i].rvalid;
      end
    end
    wait_idle();

    // unpitched layers, count beyond the maximum, unpitched edge voices
    cfg_all(7, 0, 0, 5000, VAL_MAX, 0, 0, 3);
    for (int i = 0; i < 12; i++) send_random();
    send_req(KIND_PITCH, VAL_MAX, base);
    send_req(KIND_PITCH, 0, base);
    wait_idle();

    // random phases; the extremes come first, the last one has no idling
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: cfg_all(4, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, VAL_MAX, 3);
        1: cfg_all(1, 1, 2, 3, 4, 1, 1, 1);
        2: cfg_all(0, 0, 0, 0, 0, 0, 0, 0);
        3: cfg_random(4000);
        4: cfg_random(60000);
        default: cfg_random(($urandom_range(0, 1) != 0) ? 200 : 200000);
      endcase
      if (ph == 4) hold_req = 1'b1;
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < 36; i++) send_random();
      wait_idle();
    end

    $display("covered %0d requests over %0d register settings, %0d voice results checked",
             req_cnt, phase_cnt, res_cnt);
    $display("gain and pitch updates, ramps, crossfades, unpitched and unordered layers");
    run_done = 1'b1;
  end

  // receiver: random stall bursts, one long hold-off, none at the end
  initial begin
    int unsigned len;
    bit          hold_done;
    hold_done = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk_i);
      end else if (quiet || $urandom_range(0, 1) == 0) begin
        out_stall_i <= 1'b0;
        len = $urandom_range(1, 16);
        repeat (len) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        len = $urandom_range(1, 16);
        repeat (len) @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    voice_res_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      res_cnt++;
      if (voice_q.size() == 0) begin
        report_mismatch("owed results", 0, 1);
      end else begin
        w = voice_q.pop_front();
        if (out_voice_class_o !== w.cls) report_mismatch("voice_class", out_voice_class_o, w.cls);
        if (out_layer_index_o !== w.idx[1:0])
          report_mismatch("layer_index", out_layer_index_o, w.idx);
        if (out_voice_gain_o !== w.gain[15:0])
          report_mismatch("voice_gain", out_voice_gain_o, w.gain);
        if (out_pitch_ratio_o !== w.ratio[15:0])
          report_mismatch("pitch_ratio", out_pitch_ratio_o, w.ratio);
        if (out_ratio_valid_o !== w.rvalid)
          report_mismatch("ratio_valid", out_ratio_valid_o, w.rvalid);
        if (out_last_o !== w.last) report_mismatch("last", out_last_o, w.last);
      end
    end
  end

  // watchdog on cycles with no handshake on either side; also ends the run
  always @(posedge clk_i) begin
    if (run_done) begin
      if (voice_q.size() != 0) report_mismatch("owed results at end", voice_q.size(), 0);
      if (fail_cnt == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_MAX) begin
      $display("timeout after %0d cycles without progress", idle_cyc);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

endmodule
`default_nettype wire

// File: files.f
rtl/plcf_pkg.sv
rtl/plcf_div.sv
rtl/pitch_layer_crossfade_top.sv
rtl/plcf_chk.sv
verif/pitch_layer_crossfade_top_tb.sv
